// ===== rtl/lcov_pkg.sv =====
// shared types, constants and tables for the corridor obstacle veto block
package lcov_pkg;

    localparam int NUM_MOVES    = 4;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);

    localparam logic [15:0] CLEAR_RST = 16'd300;
    localparam logic [15:0] ASTART_RST = 16'h8000;
    localparam logic [15:0] ASTEP_RST = 16'd64;
    localparam logic [2:0]  MOVES_RST = 3'd4;
    localparam logic [15:0] GAIN_Q15 = 16'd19898;

    localparam logic [2:0] REG_CLEARANCE = 3'd0;
    localparam logic [2:0] REG_ASTART    = 3'd1;
    localparam logic [2:0] REG_ASTEP     = 3'd2;
    localparam logic [2:0] REG_MOVES     = 3'd3;
    localparam logic [2:0] REG_MOVE1     = 3'd4;
    localparam logic [2:0] REG_MOVE2     = 3'd5;
    localparam logic [2:0] REG_MOVE3     = 3'd6;
    localparam logic [2:0] REG_MOVE4     = 3'd7;

    typedef struct packed {
        logic [15:0] range_mm;
        logic        range_finite;
        logic        last_beam;
    } beam_t;

    typedef struct packed {
        logic [3:0]  veto_mask;
        logic [15:0] nearest_mm;
        logic        obstacle_found;
    } veto_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request, set up cordic
        logic iterate;   // one cordic micro-rotation
        logic mult;      // range products
        logic judge;     // corridor test and nearest update
        logic finish;    // build result, clear scan, or advance angle
    } cmd_t;

    typedef struct packed {
        logic finite;
        logic last;
        logic iter_done;
    } status_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:  r = 32'h20000000;
                5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B;
                5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;
                5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;
                5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;
                5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA;
                5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;
                5'd19: r = 32'h00000518;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/lcov_ctrl.sv =====
// sequencer for one beam: load, cordic iterations, multiply, judge, finish
module lcov_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  lcov_pkg::status_t  status,
    output lcov_pkg::cmd_t     cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ITER = 3'd1;
    localparam logic [2:0] S_MULT = 3'd2;
    localparam logic [2:0] S_JUDG = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;

    // a new result may only be built once the old one has left
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg;
        cmd         = '0;
        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_ITER;
                end
            end
            S_ITER:
            begin
                cmd.iterate = 1'b1;
                if (status.iter_done || !status.finite)
                    state_next = S_MULT;
            end
            S_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = S_JUDG;
            end
            S_JUDG:
            begin
                cmd.judge  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!status.last || !ovalid_next)
                begin
                    cmd.finish = 1'b1;
                    if (status.last)
                        ovalid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

`ifndef SYNTHESIS
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE)
        else $error("load outside idle");
    a_fin_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && status.last) |-> (!ovalid_reg || out_ready))
        else $error("result overwritten");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("multiple commands");
`endif

endmodule

// ===== rtl/lcov_dp.sv =====
// datapath: config registers, cordic, corridor test and scan state
module lcov_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  lcov_pkg::beam_t    beam,
    input  lcov_pkg::cmd_t     cmd,
    output lcov_pkg::status_t  status,
    output lcov_pkg::veto_t    result
);

    logic [15:0] clear_reg, astart_reg, astep_reg;
    logic [2:0]  moves_reg;
    logic [15:0] mdist_reg [lcov_pkg::NUM_MOVES];

    logic [15:0] angle_reg, near_reg;
    logic        found_reg;
    lcov_pkg::beam_t beam_reg;
    logic        flip_reg;
    logic signed [18:0] x_reg, y_reg;
    logic signed [33:0] z_reg;
    logic [lcov_pkg::STEP_W-1:0] step_reg;
    logic signed [33:0] p_reg, q_reg;
    lcov_pkg::veto_t res_reg;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg    <= lcov_pkg::CLEAR_RST;
            astart_reg   <= lcov_pkg::ASTART_RST;
            astep_reg    <= lcov_pkg::ASTEP_RST;
            moves_reg    <= lcov_pkg::MOVES_RST;
            mdist_reg[0] <= 16'd250;
            mdist_reg[1] <= 16'd500;
            mdist_reg[2] <= 16'd1000;
            mdist_reg[3] <= 16'd2000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lcov_pkg::REG_CLEARANCE: clear_reg    <= cfg_data;
                lcov_pkg::REG_ASTART:    astart_reg   <= cfg_data;
                lcov_pkg::REG_ASTEP:     astep_reg    <= cfg_data;
                lcov_pkg::REG_MOVES:     moves_reg    <= cfg_data[2:0];
                lcov_pkg::REG_MOVE1:     mdist_reg[0] <= cfg_data;
                lcov_pkg::REG_MOVE2:     mdist_reg[1] <= cfg_data;
                lcov_pkg::REG_MOVE3:     mdist_reg[2] <= cfg_data;
                lcov_pkg::REG_MOVE4:     mdist_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // angle fold into [-pi/2, pi/2)
    logic        flip_c;
    logic [15:0] fold_c;
    assign flip_c = (angle_reg[15:14] == 2'b01) || (angle_reg[15:14] == 2'b10);
    assign fold_c = flip_c ? (angle_reg ^ 16'h8000) : angle_reg;

    // one micro-rotation, arithmetic shift is floor
    logic signed [18:0] dx_c, dy_c;
    logic signed [33:0] at_c;
    assign dx_c = y_reg >>> step_reg;
    assign dy_c = x_reg >>> step_reg;
    assign at_c = $signed({2'b00, lcov_pkg::atan_turn(5'(step_reg))});

    // clamp and fold back
    logic signed [16:0] c_c, s_c;
    function automatic logic signed [16:0] clampf(input logic signed [18:0] v,
                                                 input logic neg);
        logic signed [16:0] r;
        begin
            if (v > 19'sd32767)       r = 17'sd32767;
            else if (v < -19'sd32767) r = -17'sd32767;
            else                      r = v[16:0];
            return neg ? -r : r;
        end
    endfunction
    assign c_c = clampf(x_reg, flip_reg);
    assign s_c = clampf(y_reg, flip_reg);

    logic signed [33:0] rng_c;
    logic [33:0] qabs_c;
    logic [31:0] clr_scaled_c;
    logic [34:0] fwd_wide_c;
    logic [15:0] fwd_c;
    logic        hit_c;
    assign rng_c = $signed({18'd0, beam_reg.range_mm});
    assign qabs_c = q_reg[33] ? 34'(-q_reg) : 34'(q_reg);
    assign clr_scaled_c = {1'b0, clear_reg, 15'd0};
    assign fwd_wide_c = {1'b0, p_reg} + 35'd32767;
    assign fwd_c = (|fwd_wide_c[34:31]) ? 16'hFFFF : fwd_wide_c[30:15];
    assign hit_c = beam_reg.range_finite && !p_reg[33] && (p_reg != 34'sd0)
                   && (qabs_c <= {2'b00, clr_scaled_c});

    // veto mask
    logic [3:0] mask_c;
    logic [2:0] cnt_c;
    assign cnt_c = (moves_reg > 3'(lcov_pkg::NUM_MOVES)) ? 3'(lcov_pkg::NUM_MOVES)
                                                          : moves_reg;
    always_comb
    begin
        mask_c = '0;
        for (int k = 0; k < lcov_pkg::NUM_MOVES; k++)
        begin
            if (found_reg && (3'(k) < cnt_c)
                && ({1'b0, mdist_reg[k]} + {1'b0, clear_reg} >= {1'b0, near_reg}))
                mask_c[k] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg <= lcov_pkg::ASTART_RST;
            near_reg  <= 16'hFFFF;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.judge && hit_c)
            begin
                found_reg <= 1'b1;
                if (fwd_c < near_reg)
                    near_reg <= fwd_c;
            end
            if (cmd.finish)
            begin
                if (beam_reg.last_beam)
                begin
                    angle_reg <= astart_reg;
                    near_reg  <= 16'hFFFF;
                    found_reg <= 1'b0;
                end
                else
                    angle_reg <= angle_reg + astep_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            beam_reg <= beam;
            flip_reg <= flip_c;
            x_reg    <= $signed({3'b000, lcov_pkg::GAIN_Q15});
            y_reg    <= '0;
            z_reg    <= $signed({{2{fold_c[15]}}, fold_c, 16'd0});
            step_reg <= '0;
        end
        else if (cmd.iterate)
        begin
            if (!z_reg[33])
            begin
                x_reg <= x_reg - dx_c;
                y_reg <= y_reg + dy_c;
                z_reg <= z_reg - at_c;
            end
            else
            begin
                x_reg <= x_reg + dx_c;
                y_reg <= y_reg - dy_c;
                z_reg <= z_reg + at_c;
            end
            step_reg <= step_reg + 1'b1;
        end
        if (cmd.mult)
        begin
            p_reg <= rng_c * 34'(c_c);
            q_reg <= rng_c * 34'(s_c);
        end
        if (cmd.finish && beam_reg.last_beam)
        begin
            res_reg.veto_mask      <= mask_c;
            res_reg.nearest_mm     <= near_reg;
            res_reg.obstacle_found <= found_reg;
        end
    end

    assign status.finite    = beam_reg.range_finite;
    assign status.last      = beam_reg.last_beam;
    assign status.iter_done = (step_reg == lcov_pkg::STEP_W'(lcov_pkg::CORDIC_STEPS - 1));
    assign result = res_reg;

`ifndef SYNTHESIS
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.iterate |-> step_reg < lcov_pkg::STEP_W'(lcov_pkg::CORDIC_STEPS))
        else $error("cordic overran");
    a_found_near: assert property (@(posedge clk) disable iff (!rst_n)
        !found_reg |-> near_reg == 16'hFFFF)
        else $error("nearest set without obstacle");
    a_mask_found: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && beam_reg.last_beam && !found_reg) |=> res_reg.veto_mask == 4'd0)
        else $error("veto without obstacle");
`endif

endmodule

// ===== rtl/lidar_corridor_obstacle_veto_top.sv =====
// Forward corridor obstacle veto, one lidar beam per request.
// Input channel in_valid/in_ready carries a beam (range, finite, last flag);
// output channel out_valid/out_ready carries one result per scan, produced
// only on the request marked last_beam.
// Each beam walks a 16-step iterative CORDIC, one micro-rotation per cycle,
// then a multiply step, a judge step and a finish step; a non-finite beam
// leaves the CORDIC after its first micro-rotation. The result register is
// loaded in the finish step of a last beam, and out_valid rises together
// with it. A new beam is accepted only while the sequencer is idle, once the
// previous beam has passed its finish step.
// The configuration port (cfg_we, cfg_index, cfg_data) writes a register at
// once; write only while idle.
// Reset clears the scan: angle to angle_start, nearest to 65535, no obstacle,
// and all configuration registers to their defaults.
// When the receiver stalls, the finished result is held and a further beam
// is still accepted and processed; the block only waits at the finish of the
// next last beam until the held result has been taken.
module lidar_corridor_obstacle_veto_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  lcov_pkg::beam_t   in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output lcov_pkg::veto_t   out_data
);

    lcov_pkg::cmd_t    cmd;
    lcov_pkg::status_t status;

    lcov_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    lcov_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .beam      (in_data),
        .cmd       (cmd),
        .status    (status),
        .result    (out_data)
    );

endmodule
